FILE: design/vccr_pkg.sv
// Shared types, register offsets and operation codes of the video card control registers.
`timescale 1ns / 1ps
package vccr_pkg;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [13:0] OFS_HSTART_LO = 14'h3808;
	localparam logic [13:0] OFS_HSTART_HI = 14'h380a;
	localparam logic [13:0] OFS_HEND_LO   = 14'h380c;
	localparam logic [13:0] OFS_HEND_HI   = 14'h380e;
	localparam logic [13:0] OFS_HTOTAL_LO = 14'h3810;
	localparam logic [13:0] OFS_HTOTAL_HI = 14'h3812;
	localparam logic [13:0] OFS_VSTART_LO = 14'h381c;
	localparam logic [13:0] OFS_VSTART_HI = 14'h381e;
	localparam logic [13:0] OFS_VEND_LO   = 14'h3824;
	localparam logic [13:0] OFS_VEND_HI   = 14'h3826;
	localparam logic [13:0] OFS_VTOTAL_LO = 14'h3828;
	localparam logic [13:0] OFS_VTOTAL_HI = 14'h382a;
	localparam logic [13:0] OFS_STAT_A    = 14'h382c;
	localparam logic [13:0] OFS_STAT_B    = 14'h382e;
	localparam logic [13:0] OFS_IRQ_CTRL  = 14'h385c;
	localparam logic [13:0] OFS_CLUT_PTR  = 14'h3a00;
	localparam logic [13:0] OFS_CLUT_DATA = 14'h3a01;
	localparam logic [13:0] OFS_MODE      = 14'h3c00;
	localparam logic [13:0] OFS_MODE_SEQ  = 14'h3e02;

	localparam logic [31:0] RD_STAT_BYTE  = 32'h0000_00ff;
	localparam logic [31:0] RD_STAT_WORD  = 32'hffff_fff5;
	localparam logic [31:0] RD_IRQ_PEND   = 32'h0000_0008;
	localparam logic [31:0] MODE_IGNORE   = 32'hffff_ffff;
	localparam logic [7:0]  MODE_BYTE_MIN = 8'h5c;
	localparam logic [7:0]  MODE_BYTE_MAX = 8'h5f;
	localparam int unsigned IRQ_OFF_BIT   = 4;
	localparam logic signed [15:0] VTOTAL_INTERLACE = -16'sd262;

	typedef struct packed {
		logic [7:0]  palette_blue;
		logic [7:0]  palette_green;
		logic [7:0]  palette_red;
		logic [7:0]  palette_index;
		logic        palette_we;
		logic        timing_ok;
		logic        interlaced;
		logic [1:0]  pixel_mode;
		logic        irq_level;
		logic [31:0] read_data;
	} result_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = v[i];
		end
		return r;
	endfunction

endpackage

FILE: design/video_card_control_registers.sv
// Top level of the video card control registers: input register, decode and result register.
`timescale 1ns / 1ps
// An accepted input beat passes through the input register and then the result register to the master side.
// Throughput: one beat per cycle; the input register and the result register both advance
// together whenever the result register is empty or its beat is being taken.
// Reset: arst_n clears both valid flags and loads the timing, interrupt, mode, palette
// pointer and sequence registers with their power-on values; payload registers are not reset.
module video_card_control_registers
	import vccr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // reg_offset[13:0], write_data[45:14], zero pad[47:46]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // read_data[31:0], irq_level[32], pixel_mode[34:33],
	                               // interlaced[35], timing_ok[36], palette_we[37],
	                               // palette_index[45:38], palette_red[53:46],
	                               // palette_green[61:54], palette_blue[69:62], zero[71:70]
);

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [13:0] ofs_s1;
	logic [31:0] data_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res;
	logic        adv;

	// Move the held beat into the result register when that register is free or drained.
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	// Take a new beat whenever the input register is empty or emptying this cycle.
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers: hold unless their stage advances.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			ofs_s1  <= s_tdata[13:0];
			data_s1 <= s_tdata[45:14];
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	// Decode and state update; the state commits only as the beat leaves the input register.
	vccr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.operation  (op_s1),
		.reg_offset (ofs_s1),
		.write_data (data_s1),
		.res        (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2};

endmodule

FILE: design/vccr_core.sv
// Register state of the control space and the result of one bus beat.
`timescale 1ns / 1ps
module vccr_core
	import vccr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [1:0]  operation,
	input  logic [13:0] reg_offset,
	input  logic [31:0] write_data,
	output result_t     res
);

	logic signed [15:0] hstart_q, hend_q, htotal_q, vstart_q, vend_q, vtotal_q;
	logic signed [15:0] hstart_d, hend_d, htotal_d, vstart_d, vend_d, vtotal_d;
	logic        irq_off_q, irq_off_d;
	logic        pending_q, pending_d;
	logic [1:0]  mode_q, mode_d;
	logic [7:0]  ptr_q, ptr_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [7:0]  held0_q, held0_d, held1_q, held1_d;
	logic [2:0]  seq_q, seq_d;
	logic [7:0]  dbyte, cbyte;

	function automatic logic [15:0] merge(input logic [15:0] r, input logic hi,
		input logic [7:0] b);
		return hi ? {b, r[7:0]} : {r[15:8], b};
	endfunction

	assign dbyte = write_data[7:0];
	assign cbyte = ~dbyte;

	always_comb begin
		hstart_d  = hstart_q;
		hend_d    = hend_q;
		htotal_d  = htotal_q;
		vstart_d  = vstart_q;
		vend_d    = vend_q;
		vtotal_d  = vtotal_q;
		irq_off_d = irq_off_q;
		pending_d = pending_q;
		mode_d    = mode_q;
		ptr_d     = ptr_q;
		cnt_d     = cnt_q;
		held0_d   = held0_q;
		held1_d   = held1_q;
		seq_d     = seq_q;
		res       = '0;

		case (op_t'(operation))
			OP_WRITE: begin
				case (reg_offset)
					OFS_HSTART_LO, OFS_HSTART_HI:
						hstart_d = merge(hstart_q, reg_offset[1], dbyte);
					OFS_HEND_LO, OFS_HEND_HI:
						hend_d = merge(hend_q, reg_offset[1], dbyte);
					OFS_HTOTAL_LO, OFS_HTOTAL_HI:
						htotal_d = merge(htotal_q, reg_offset[1], dbyte);
					OFS_VSTART_LO, OFS_VSTART_HI:
						vstart_d = merge(vstart_q, reg_offset[1], dbyte);
					OFS_VEND_LO, OFS_VEND_HI:
						vend_d = merge(vend_q, reg_offset[1], dbyte);
					OFS_VTOTAL_LO, OFS_VTOTAL_HI:
						vtotal_d = merge(vtotal_q, reg_offset[1], dbyte);
					OFS_IRQ_CTRL: begin
						irq_off_d = write_data[IRQ_OFF_BIT];
						if (write_data[IRQ_OFF_BIT]) begin
							pending_d = 1'b0;
						end
					end
					OFS_CLUT_PTR: ptr_d = cbyte;
					OFS_CLUT_DATA: begin
						if (cnt_q[1]) begin
							res.palette_we    = 1'b1;
							res.palette_index = rev8(ptr_q);
							res.palette_red   = held0_q;
							res.palette_green = held1_q;
							res.palette_blue  = cbyte;
							ptr_d = ptr_q + 8'd1;
							cnt_d = 2'd0;
						end else begin
							if (cnt_q[0]) begin
								held1_d = cbyte;
							end else begin
								held0_d = cbyte;
							end
							cnt_d = cnt_q + 2'd1;
						end
					end
					OFS_MODE: begin
						if (seq_q == 3'd2 && write_data != MODE_IGNORE &&
								dbyte >= MODE_BYTE_MIN && dbyte <= MODE_BYTE_MAX) begin
							mode_d = ~dbyte[1:0];
						end
						if (seq_q != 3'd7) begin
							seq_d = seq_q + 3'd1;
						end
					end
					OFS_MODE_SEQ: begin
						if (write_data == 32'd1) begin
							seq_d = 3'd0;
						end
					end
					default: ;
				endcase
			end
			OP_READ: begin
				case (reg_offset)
					OFS_VEND_HI, OFS_STAT_B: res.read_data = RD_STAT_BYTE;
					OFS_VEND_LO, OFS_STAT_A: res.read_data = RD_STAT_WORD;
					OFS_IRQ_CTRL: res.read_data = pending_q ? RD_IRQ_PEND : '0;
					default: res.read_data = '0;
				endcase
			end
			OP_TICK: begin
				if (!irq_off_q) begin
					pending_d = 1'b1;
				end
			end
			default: ;
		endcase

		res.irq_level  = pending_d;
		res.pixel_mode = mode_d;
		res.interlaced = (vtotal_d == VTOTAL_INTERLACE);
		res.timing_ok  = (hend_d < hstart_d) && (htotal_d < hend_d) &&
			(vend_d < vstart_d) && (vtotal_d < vend_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstart_q  <= -16'sd64;
			hend_q    <= -16'sd320;
			htotal_q  <= -16'sd332;
			vstart_q  <= -16'sd33;
			vend_q    <= -16'sd801;
			vtotal_q  <= -16'sd804;
			irq_off_q <= 1'b1;
			pending_q <= 1'b0;
			mode_q    <= 2'd0;
			ptr_q     <= 8'd0;
			cnt_q     <= 2'd0;
			held0_q   <= 8'd0;
			held1_q   <= 8'd0;
			seq_q     <= 3'd0;
		end else if (step) begin
			hstart_q  <= hstart_d;
			hend_q    <= hend_d;
			htotal_q  <= htotal_d;
			vstart_q  <= vstart_d;
			vend_q    <= vend_d;
			vtotal_q  <= vtotal_d;
			irq_off_q <= irq_off_d;
			pending_q <= pending_d;
			mode_q    <= mode_d;
			ptr_q     <= ptr_d;
			cnt_q     <= cnt_d;
			held0_q   <= held0_d;
			held1_q   <= held1_d;
			seq_q     <= seq_d;
		end
	end

endmodule
